/* rtl/assert_macros.svh */
// Assertion macros shared by the segment pair closest-point RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`endif

/* rtl/spcp_pkg.sv */
// Package for the segment pair closest-point unit: widths and defaults.
// Depends on nothing.
package spcp_pkg;
	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF = 30;
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] REG_ZERO_TOL = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_U_SNAP = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_V_SNAP = 2'd2;
	localparam logic [30:0] ZERO_TOL_RST = 31'd1074;
	localparam int QW = 32;
endpackage

/* rtl/spcp_div.sv */
// Pipelined restoring divider: one quotient bit per stage, saturating to 32 bits.
// Depends on spcp_pkg and assert_macros.svh.
module spcp_div #(
	parameter int NW = 100,
	parameter int DW = 100,
	parameter int FB = 30
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic          neg,
	output logic          out_vld,
	output logic signed [31:0] quo
);
	import spcp_pkg::*;
	localparam int RW = NW + FB + 1;
	localparam int ST = 32;
	logic [RW-1:0] rem_s [ST+1];
	logic [DW-1:0] den_s [ST+1];
	logic [QW-1:0] q_s [ST+1];
	logic neg_s [ST+1];
	logic vld_s [ST+1];
	logic sat_s [ST+1];
	logic [RW+DW:0] tr [ST];
	logic signed [31:0] res;

	assign rem_s[0] = {1'b0, num, {FB{1'b0}}};
	assign den_s[0] = den;
	assign q_s[0] = '0;
	assign neg_s[0] = neg;
	assign vld_s[0] = in_vld;
	assign sat_s[0] = 1'b0;

	for (genvar g = 0; g < ST; g++) begin : g_st
		localparam int SH = 31 - g;
		assign tr[g] = (RW+DW+1)'(den_s[g]) << SH;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end
		always_ff @(posedge clk) begin
			den_s[g+1] <= den_s[g];
			neg_s[g+1] <= neg_s[g];
			if ({{(DW+1){1'b0}}, rem_s[g]} >= tr[g]) begin
				rem_s[g+1] <= rem_s[g] - tr[g][RW-1:0];
				q_s[g+1] <= q_s[g] | (QW'(1) << SH);
				sat_s[g+1] <= sat_s[g] | (g == 0);
			end else begin
				rem_s[g+1] <= rem_s[g];
				q_s[g+1] <= q_s[g];
				sat_s[g+1] <= sat_s[g];
			end
		end
	end

	always_comb begin
		if (sat_s[ST]) begin
			res = neg_s[ST] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			res = neg_s[ST] ? -$signed(q_s[ST]) : $signed(q_s[ST]);
		end
	end
	assign quo = res;
	assign out_vld = vld_s[ST];

	`include "assert_macros.svh"
	`ASSERT_NEXT(a_vld_flow, clk, arst_n, vld_s[0], vld_s[1])
	`ASSERT_IMPL(a_nosat_top, clk, arst_n, vld_s[ST] && !sat_s[ST], !q_s[ST][31])
	`ASSERT_NEXT(a_idle_flow, clk, arst_n, !vld_s[0], !vld_s[1])
endmodule

/* rtl/segment_pair_closest_params_unit.sv */
// Top level of the segment pair closest-point unit.
// Depends on spcp_pkg, spcp_div and assert_macros.svh.
//
// Use: drive the twelve coordinates and pulse start while busy is low; busy
// is always low, so one item may enter every cycle. Each item yields one
// result on u_param, v_param, found and degenerate, marked by done for one
// cycle; done rises as the item leaves the last of 39 register stages
// (differences, products, dot sums, partial products, cross sums,
// combine, 32 divider stages, then snapping). Throughput is one item per
// cycle; the divider is a 32-stage restoring pipeline, one quotient bit per
// stage. Config: cfg_valid/cfg_ready with cfg_index 0 zero_tol, 1 u_snap,
// 2 v_snap; cfg_ready is always high; write only while idle. Reset clears
// valid bits and loads register defaults; the receiver cannot stall,
// results are never held.
module segment_pair_closest_params_unit #(
	parameter int COORD_BITS = spcp_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS = spcp_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [spcp_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic signed [COORD_BITS-1:0] a_start_x,
	input  logic signed [COORD_BITS-1:0] a_start_y,
	input  logic signed [COORD_BITS-1:0] a_start_z,
	input  logic signed [COORD_BITS-1:0] a_end_x,
	input  logic signed [COORD_BITS-1:0] a_end_y,
	input  logic signed [COORD_BITS-1:0] a_end_z,
	input  logic signed [COORD_BITS-1:0] b_start_x,
	input  logic signed [COORD_BITS-1:0] b_start_y,
	input  logic signed [COORD_BITS-1:0] b_start_z,
	input  logic signed [COORD_BITS-1:0] b_end_x,
	input  logic signed [COORD_BITS-1:0] b_end_y,
	input  logic signed [COORD_BITS-1:0] b_end_z,
	output logic done,
	output logic signed [31:0] u_param,
	output logic signed [31:0] v_param,
	output logic found,
	output logic degenerate
);
	import spcp_pkg::*;
	localparam int DB = COORD_BITS + 1;
	localparam int PB = 2 * DB;
	localparam int KB = PB + 2;
	localparam int HB = KB / 2;
	localparam int XB = 2 * KB + 1;
	localparam int MB = XB;
	localparam int SH = 30 - FRAC_BITS;
	localparam int DLY = 32;

	logic [30:0] zero_tol_q;
	logic [29:0] u_snap_q, v_snap_q;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_tol_q <= ZERO_TOL_RST;
			u_snap_q <= '0;
			v_snap_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ZERO_TOL: zero_tol_q <= cfg_data[30:0];
				REG_U_SNAP: u_snap_q <= cfg_data[29:0];
				REG_V_SNAP: v_snap_q <= cfg_data[29:0];
				default: ;
			endcase
		end
	end

	// stage 1: differences
	logic signed [DB-1:0] ax_s1, ay_s1, az_s1, bx_s1, by_s1, bz_s1, wx_s1, wy_s1, wz_s1;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
		end else begin
			v_s1 <= start; v_s2 <= v_s1; v_s3 <= v_s2;
			v_s4 <= v_s3; v_s5 <= v_s4; v_s6 <= v_s5;
		end
	end
	always_ff @(posedge clk) begin
		ax_s1 <= DB'(a_end_x) - DB'(a_start_x);
		ay_s1 <= DB'(a_end_y) - DB'(a_start_y);
		az_s1 <= DB'(a_end_z) - DB'(a_start_z);
		bx_s1 <= DB'(b_end_x) - DB'(b_start_x);
		by_s1 <= DB'(b_end_y) - DB'(b_start_y);
		bz_s1 <= DB'(b_end_z) - DB'(b_start_z);
		wx_s1 <= DB'(b_start_x) - DB'(a_start_x);
		wy_s1 <= DB'(b_start_y) - DB'(a_start_y);
		wz_s1 <= DB'(b_start_z) - DB'(a_start_z);
	end

	// stage 2: 15 products
	logic signed [PB-1:0] p_s2 [15];
	always_ff @(posedge clk) begin
		p_s2[0] <= bx_s1 * bx_s1; p_s2[1] <= by_s1 * by_s1; p_s2[2] <= bz_s1 * bz_s1;
		p_s2[3] <= ax_s1 * bx_s1; p_s2[4] <= ay_s1 * by_s1; p_s2[5] <= az_s1 * bz_s1;
		p_s2[6] <= wx_s1 * bx_s1; p_s2[7] <= wy_s1 * by_s1; p_s2[8] <= wz_s1 * bz_s1;
		p_s2[9] <= ax_s1 * ax_s1; p_s2[10] <= ay_s1 * ay_s1; p_s2[11] <= az_s1 * az_s1;
		p_s2[12] <= ax_s1 * wx_s1; p_s2[13] <= ay_s1 * wy_s1; p_s2[14] <= az_s1 * wz_s1;
	end

	// stage 3: dot products
	logic signed [KB-1:0] k_s3 [5];
	always_ff @(posedge clk) begin
		for (int i = 0; i < 5; i++) begin
			k_s3[i] <= KB'(p_s2[3*i]) + KB'(p_s2[3*i+1]) + KB'(p_s2[3*i+2]);
		end
	end
	// k_s3: 0 k1, 1 k2, 2 k3, 3 k11, 4 k33

	// stage 4: half-width partial products of the six cross products
	logic signed [KB-1:0] ma [6], mb [6];
	assign ma[0] = k_s3[3]; assign mb[0] = k_s3[0];
	assign ma[1] = k_s3[1]; assign mb[1] = k_s3[1];
	assign ma[2] = k_s3[4]; assign mb[2] = k_s3[0];
	assign ma[3] = k_s3[1]; assign mb[3] = k_s3[2];
	assign ma[4] = k_s3[1]; assign mb[4] = k_s3[4];
	assign ma[5] = k_s3[3]; assign mb[5] = k_s3[2];

	// signed upper half, unsigned lower half
	logic signed [HB-1:0] ah [6], bh [6];
	logic signed [HB:0] al [6], bl [6];
	for (genvar g = 0; g < 6; g++) begin : g_split
		assign ah[g] = ma[g][KB-1:HB];
		assign bh[g] = mb[g][KB-1:HB];
		assign al[g] = {1'b0, ma[g][HB-1:0]};
		assign bl[g] = {1'b0, mb[g][HB-1:0]};
	end

	logic signed [KB-1:0] hh_s4 [6];
	logic signed [KB:0] hl_s4 [6], lh_s4 [6];
	logic signed [KB+1:0] ll_s4 [6];
	logic k1z_s4, k1z_s5;
	always_ff @(posedge clk) begin
		for (int i = 0; i < 6; i++) begin
			hh_s4[i] <= ah[i] * bh[i];
			hl_s4[i] <= ah[i] * bl[i];
			lh_s4[i] <= al[i] * bh[i];
			ll_s4[i] <= al[i] * bl[i];
		end
		k1z_s4 <= (k_s3[0] == '0);
	end

	// stage 5: cross products
	logic signed [XB-1:0] x_s5 [6];
	always_ff @(posedge clk) begin
		for (int i = 0; i < 6; i++) begin
			x_s5[i] <= (XB'(hh_s4[i]) <<< (2 * HB)) + (XB'(hl_s4[i]) <<< HB)
				+ (XB'(lh_s4[i]) <<< HB) + XB'(ll_s4[i]);
		end
		k1z_s5 <= k1z_s4;
	end

	// stage 6: numerators, divisor, magnitudes
	logic signed [XB-1:0] dd, nu, nv;
	logic [MB-1:0] dm_s6, um_s6, vm_s6;
	logic un_s6, vn_s6, dg_s6;
	assign dd = x_s5[0] - x_s5[1];
	assign nu = x_s5[2] - x_s5[3];
	assign nv = x_s5[4] - x_s5[5];
	always_ff @(posedge clk) begin
		dm_s6 <= dd[XB-1] ? MB'(-dd) : MB'(dd);
		um_s6 <= nu[XB-1] ? MB'(-nu) : MB'(nu);
		vm_s6 <= nv[XB-1] ? MB'(-nv) : MB'(nv);
		un_s6 <= nu[XB-1];
		vn_s6 <= nv[XB-1];
		dg_s6 <= k1z_s5 || (dd == '0);
	end

	logic [MB-1:0] dsafe;
	assign dsafe = dg_s6 ? MB'(1) : dm_s6;
	logic qv_u, qv_v;
	logic signed [31:0] qu, qv;
	spcp_div #(.NW(MB), .DW(MB), .FB(FRAC_BITS)) u_div_u (
		.clk, .arst_n, .in_vld(v_s6), .num(um_s6), .den(dsafe), .neg(un_s6),
		.out_vld(qv_u), .quo(qu));
	spcp_div #(.NW(MB), .DW(MB), .FB(FRAC_BITS)) u_div_v (
		.clk, .arst_n, .in_vld(v_s6), .num(vm_s6), .den(dsafe), .neg(vn_s6),
		.out_vld(qv_v), .quo(qv));

	logic dg_d [DLY+1];
	assign dg_d[0] = dg_s6;
	for (genvar g = 0; g < DLY; g++) begin : g_dg
		always_ff @(posedge clk) dg_d[g+1] <= dg_d[g];
	end

	// final: range test and snapping
	logic signed [33:0] one, tol, us, vs, u34, v34, uo, vo;
	logic uin, vin;
	always_comb begin
		one = 34'sd1 <<< FRAC_BITS;
		tol = $signed({3'b000, zero_tol_q >> SH});
		us = $signed({4'b0000, u_snap_q >> SH});
		vs = $signed({4'b0000, v_snap_q >> SH});
		u34 = 34'(qu);
		v34 = 34'(qv);
		uin = (u34 > -tol) && (u34 < one + tol);
		vin = (v34 > -tol) && (v34 < one + tol);
		uo = u34;
		vo = v34;
		if (uin) begin
			if (u34 < us) uo = '0;
			else if (u34 > one - us) uo = one;
			if (vin) begin
				if (v34 < vs) vo = '0;
				else if (v34 > one - vs) vo = one;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= qv_u;
		end
	end
	always_ff @(posedge clk) begin
		u_param <= dg_d[DLY] ? '0 : uo[31:0];
		v_param <= dg_d[DLY] ? '0 : vo[31:0];
		found <= !dg_d[DLY] && uin && vin;
		degenerate <= dg_d[DLY];
	end

	`include "assert_macros.svh"
	`ASSERT_IMPL(a_div_lock, clk, arst_n, 1'b1, qv_u == qv_v)
	`ASSERT_NEXT(a_done_follows, clk, arst_n, qv_u, done)
	`ASSERT_IMPL(a_found_excl, clk, arst_n, done, !(found && degenerate))
endmodule
